// ===== rtl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// Types, codes and default sizes shared by the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 32;

  // request codes
  localparam logic [2:0] FN_INS_SORTED = 3'd0;
  localparam logic [2:0] FN_SRCH_SORTED = 3'd1;
  localparam logic [2:0] FN_SRCH_LINEAR = 3'd2;
  localparam logic [2:0] FN_INS_AT     = 3'd3;
  localparam logic [2:0] FN_APPEND     = 3'd4;
  localparam logic [2:0] FN_REMOVE_AT  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] key;
    logic [4:0]  index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] index_res;
    logic [4:0] count;
  } out_item_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } shift_ctl_t;

endpackage

// ===== rtl/sorted_key_table_top.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_top
// Sorted key table: a row of key cells with bisection, linear search and
// shifting insert and remove.
// ----------------------------------------------------------------------------
// One request at a time; busy is high from acceptance until the cycle in which
// the result strobe is raised, and a new item may start in that cycle. Every
// cell compares its key with the request key in parallel and registers the
// outcome; a sequencer then walks those outcomes. A rejected or unknown
// request is answered from the compare state; insert at, append and remove
// then shift the whole row at once; sorted search and insert bisect the row
// (one bisection step per cycle), and a linear search walks it (one slot per
// cycle). The receiver cannot stall: each result is on out_item for exactly
// one cycle with out_valid high. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_key_table_top
  import skt_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = (CW > 5) ? CW : 5;

  typedef enum logic [2:0] {
    S_IDLE, S_CMP, S_BIS, S_SCAN, S_INS, S_REM
  } state_t;

  state_t               state_r, state_nxt;
  logic [2:0]           func_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic [CW-1:0]        scan_r, scan_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic                 cmp_signed_r;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;

  logic [KEY_WIDTH-1:0] entry_vec [DEPTH];
  logic [DEPTH-1:0]     lt_vec;
  logic [DEPTH-1:0]     eq_vec;
  shift_ctl_t           ctl;

  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid;
  logic [CW-1:0]        rd_addr;
  logic                 rd_lt;
  logic                 rd_eq;
  logic [PW-1:0]        fill_p;
  logic [CW-1:0]        bis_res;
  logic                 bis_done;
  logic                 bis_found;

  assign ctl.ins = (state_r == S_INS);
  assign ctl.rem = (state_r == S_REM);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_k;
    logic [KEY_WIDTH-1:0] right_k;
    if (g == 0) begin : g_first
      assign left_k = key_r;
    end else begin : g_mid_l
      assign left_k = entry_vec[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_k = entry_vec[g];
    end else begin : g_mid_r
      assign right_k = entry_vec[g+1];
    end
    skt_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CW        (CW),
      .IDX       (g)
    ) u_cell (
      .clk        (clk),
      .cmp_signed (cmp_signed_r),
      .key        (key_r),
      .ctl        (ctl),
      .pos        (pos_r[CW-1:0]),
      .left_key   (left_k),
      .right_key  (right_k),
      .entry      (entry_vec[g]),
      .lt         (lt_vec[g]),
      .eq         (eq_vec[g])
    );
  end

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CW:1];
  assign fill_p  = PW'(fill_r);

  always_comb begin
    if (state_r == S_SCAN) begin
      rd_addr = scan_r;
    end else if (lo_r < hi_r) begin
      rd_addr = mid;
    end else begin
      rd_addr = lo_r;
    end
  end

  assign rd_lt = lt_vec[rd_addr[IW-1:0]];
  assign rd_eq = eq_vec[rd_addr[IW-1:0]];

  // bisection step outcome
  always_comb begin
    bis_done  = 1'b0;
    bis_found = 1'b0;
    bis_res   = lo_r;
    if (lo_r < hi_r) begin
      if (rd_eq) begin
        bis_done  = 1'b1;
        bis_found = 1'b1;
        bis_res   = mid;
      end
    end else begin
      bis_done  = 1'b1;
      bis_found = (lo_r < fill_r) && rd_eq;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    scan_nxt      = scan_r;
    fill_nxt      = fill_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          pos_nxt   = PW'(in_item.index);
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        lo_nxt   = '0;
        hi_nxt   = fill_r;
        scan_nxt = '0;
        out_nxt  = '{status: ST_OK, index_res: 5'd0, count: 5'(fill_r)};
        unique case (func_r)
          FN_INS_SORTED: begin
            if (fill_r >= CW'(DEPTH)) begin
              out_nxt.status = ST_FULL;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_BIS;
            end
          end
          FN_SRCH_SORTED: state_nxt = S_BIS;
          FN_SRCH_LINEAR: state_nxt = S_SCAN;
          FN_INS_AT, FN_APPEND: begin
            if (func_r == FN_APPEND) begin
              pos_nxt = fill_p;
            end
            if (func_r == FN_INS_AT && pos_r > fill_p) begin
              out_nxt.status = ST_RANGE;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else if (fill_r >= CW'(DEPTH)) begin
              out_nxt.status = ST_FULL;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_INS;
            end
          end
          FN_REMOVE_AT: begin
            if (pos_r >= fill_p) begin
              out_nxt.status = ST_RANGE;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_REM;
            end
          end
          default: begin
            // unknown request: report ok, change nothing
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_BIS: begin
        if (bis_done) begin
          if (func_r == FN_INS_SORTED) begin
            pos_nxt   = PW'(bis_res);
            state_nxt = S_INS;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (bis_found) begin
              out_nxt.index_res = 5'(bis_res);
            end else begin
              out_nxt.status = ST_NOT_FOUND;
            end
          end
        end else if (rd_lt) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + CW'(1);
        end
      end
      S_SCAN: begin
        if (scan_r >= fill_r) begin
          out_nxt.status = ST_NOT_FOUND;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (rd_eq) begin
          out_nxt.index_res = 5'(scan_r);
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end else begin
          scan_nxt = scan_r + CW'(1);
        end
      end
      S_INS: begin
        fill_nxt          = fill_r + CW'(1);
        out_nxt.index_res = 5'(pos_r);
        out_nxt.count     = 5'(fill_r + CW'(1));
        out_valid_nxt     = 1'b1;
        state_nxt         = S_IDLE;
      end
      S_REM: begin
        fill_nxt          = fill_r - CW'(1);
        out_nxt.index_res = 5'(pos_r);
        out_nxt.count     = 5'(fill_r - CW'(1));
        out_valid_nxt     = 1'b1;
        state_nxt         = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      cmp_signed_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cmp_signed_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    scan_r <= scan_nxt;
    out_r  <= out_nxt;
    if (state_r == S_IDLE && start) begin
      func_r <= in_item.func;
      key_r  <= KEY_WIDTH'(in_item.key);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/skt_cell.sv =====
// ----------------------------------------------------------------------------
// skt_cell
// One table slot: holds a key, compares it with the broadcast key and moves
// keys to or from its neighbours on insert and remove.
// ----------------------------------------------------------------------------
module skt_cell
  import skt_pkg::*;
#(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int CW        = 5,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  logic                 cmp_signed,
  input  logic [KEY_WIDTH-1:0] key,
  input  shift_ctl_t           ctl,
  input  logic [CW-1:0]        pos,
  input  logic [KEY_WIDTH-1:0] left_key,
  input  logic [KEY_WIDTH-1:0] right_key,
  output logic [KEY_WIDTH-1:0] entry,
  output logic                 lt,
  output logic                 eq
);

  logic [KEY_WIDTH-1:0] entry_r;
  logic [KEY_WIDTH-1:0] entry_nxt;
  logic                 lt_r;
  logic                 eq_r;
  logic [KEY_WIDTH-1:0] flip;
  logic [KEY_WIDTH-1:0] a;
  logic [KEY_WIDTH-1:0] b;
  logic [CW-1:0]        me;

  assign me   = CW'(IDX);
  // flip the sign bit so that an unsigned compare orders two's complement
  assign flip = KEY_WIDTH'(cmp_signed) << (KEY_WIDTH - 1);
  assign a    = key ^ flip;
  assign b    = entry_r ^ flip;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (me > pos) begin
        entry_nxt = left_key;
      end else if (me == pos) begin
        entry_nxt = key;
      end
    end else if (ctl.rem) begin
      if (me >= pos) begin
        entry_nxt = right_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    lt_r    <= (a < b);
    eq_r    <= (a == b);
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule
